// File: sv/ffa_pkg.sv
// Shared types, word layouts and status codes for the power-of-two region allocator.
`default_nettype none
package ffa_pkg;

  // Fixed field widths, degree bounds, region limit and node header size.
  localparam int unsigned OFFSET_BITS = 14;
  localparam int unsigned SIZE_BITS   = 15;
  localparam int unsigned DEG_BITS    = 4;
  localparam int unsigned MIN_DEGREE  = 3;
  localparam int unsigned MAX_DEGREE  = 14;
  localparam logic [14:0] REGION_LIMIT = 15'd16384;
  localparam logic [14:0] NODE_HDR_BYTES = 15'd4;

  // Request kinds.
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_OUTSIDE   = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  // Configuration register indexes.
  localparam logic [0:0] CFG_REGION = 1'b0;
  localparam logic [0:0] CFG_HEADER = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [14:0] alloc_bytes;
    logic [13:0] payload_offset;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [13:0] result_offset;
    logic [14:0] block_bytes;
    logic [14:0] usage_bytes;
  } out_word_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [14:0] value;
  } cfg_word_t;

  // Header block size from its log2, clamped to the legal degree range.
  function automatic logic [14:0] hdr_size(input logic [3:0] lg);
    logic [3:0] d;
    begin
      d = lg;
      if (d < 4'(MIN_DEGREE)) d = 4'(MIN_DEGREE);
      if (d > 4'(MAX_DEGREE)) d = 4'(MAX_DEGREE);
      hdr_size = 15'(16'd1 << d);
    end
  endfunction

endpackage
`default_nettype wire

// File: sv/ffa_stream_if.sv
// Valid/ready channel carrying one payload word.
`default_nettype none
interface ffa_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/ffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/first_fit_pow2_region_allocator.sv
// Top level: first-fit allocator of power-of-two blocks over a byte region.
// After acceptance, alloc rounds the need up degree by degree, walks the linked blocks, then
// places, links if needed and outputs; free and query walk the blocks, unlink on a free hit
// and output. One request is in work at a time; a finished word may wait while the next is
// taken. After reset, the S_CLR state fills the free-slot stack while the input is not ready.
`default_nettype none
module first_fit_pow2_region_allocator #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input wire logic    clk,
  input wire logic    rst_n,
  ffa_stream_if.sink   in_if,
  ffa_stream_if.source out_if,
  ffa_stream_if.sink   cfg_if
);
  localparam int unsigned SW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned EW = 14 + 4 + SW;
  localparam logic [CW-1:0] MAX_C   = CW'(MAX_BLOCKS);
  localparam logic [CW-1:0] MAXM1_C = CW'(MAX_BLOCKS - 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_BLOCKS - 1);

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DEG    = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_PLACE  = 3'd4;
  localparam logic [2:0] S_LINK   = 3'd5;
  localparam logic [2:0] S_UNLINK = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic [SW-1:0] clr_r, clr_nxt;
  logic [1:0]  req_r, req_nxt;
  logic [13:0] off_r, off_nxt;
  logic [3:0]  deg_r, deg_nxt;
  logic [15:0] need_r, need_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic [SW-1:0] prev_r, prev_nxt;
  logic [13:0] prev_start_r, prev_start_nxt;
  logic [3:0]  prev_deg_r, prev_deg_nxt;
  logic        has_prev_r, has_prev_nxt;
  logic        found_r, found_nxt;
  logic [CW-1:0] step_r, step_nxt;
  logic [SW-1:0] first_r, first_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [14:0] used_r, used_nxt;
  logic [14:0] region_r, region_nxt;
  logic [3:0]  hlog_r, hlog_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [SW-1:0] cur_next_r, cur_next_nxt;
  logic [3:0]  cur_deg_r, cur_deg_nxt;
  logic [2:0]  res_status_r, res_status_nxt;
  logic [13:0] res_off_r, res_off_nxt;
  logic [14:0] res_bytes_r, res_bytes_nxt;
  ffa_pkg::out_word_t out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Entry RAM: start, degree and next link of each slot.
  logic          ent_we;
  logic [SW-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0] ent_wdata, ent_q;
  logic [13:0]   q_start;
  logic [3:0]    q_deg;
  logic [SW-1:0] q_next;

  // Free-slot stack RAM.
  logic          stk_we;
  logic [SW-1:0] stk_waddr, stk_wdata, stk_raddr, stk_q;

  ffa_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_entry_ram (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_q)
  );

  ffa_ram #(.WIDTH(SW), .DEPTH(MAX_BLOCKS)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_q)
  );

  assign q_next  = ent_q[SW-1:0];
  assign q_deg   = ent_q[SW+3:SW];
  assign q_start = ent_q[EW-1:SW+4];

  // The walk follows links straight out of the read register; otherwise the head is read.
  assign ent_raddr = (state_r == S_WALK) ? q_next : first_r;
  assign stk_raddr = SW'(MAXM1_C - count_r);

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  logic [14:0] hsize, reg_end, blk_size, q_size;
  logic [16:0] pos_plus;
  logic [15:0] q_end;
  logic [14:0] q_payload;

  always_comb begin
    hsize     = ffa_pkg::hdr_size(hlog_r);
    reg_end   = (region_r > ffa_pkg::REGION_LIMIT) ? ffa_pkg::REGION_LIMIT : region_r;
    blk_size  = 15'(16'd1 << deg_r);
    q_size    = 15'(16'd1 << q_deg);
    pos_plus  = {1'b0, pos_r} + {2'b0, blk_size};
    q_end     = {2'b0, q_start} + {1'b0, q_size};
    q_payload = {1'b0, q_start} + ffa_pkg::NODE_HDR_BYTES;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;  clr_nxt = clr_r;  req_nxt = req_r;
    off_nxt = off_r;  deg_nxt = deg_r;  need_nxt = need_r;  pos_nxt = pos_r;
    cur_nxt = cur_r;  prev_nxt = prev_r;  prev_start_nxt = prev_start_r;
    prev_deg_nxt = prev_deg_r;  has_prev_nxt = has_prev_r;  found_nxt = found_r;
    step_nxt = step_r;  first_nxt = first_r;  count_nxt = count_r;  used_nxt = used_r;
    region_nxt = region_r;  hlog_nxt = hlog_r;  slot_nxt = slot_r;
    cur_next_nxt = cur_next_r;  cur_deg_nxt = cur_deg_r;
    res_status_nxt = res_status_r;  res_off_nxt = res_off_r;  res_bytes_nxt = res_bytes_r;
    out_nxt = out_r;  out_valid_nxt = out_valid_r;
    ent_we = 1'b0;  ent_waddr = cur_r;  ent_wdata = '0;
    stk_we = 1'b0;  stk_waddr = clr_r;  stk_wdata = clr_r;

    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration writes.
    if (cfg_if.valid) begin
      if (cfg_if.data.index == ffa_pkg::CFG_REGION) begin
        region_nxt = cfg_if.data.value;
      end else begin
        hlog_nxt = cfg_if.data.value[3:0];
        used_nxt = used_r - hsize + ffa_pkg::hdr_size(cfg_if.data.value[3:0]);
      end
    end

    case (state_r)
      S_CLR: begin
        stk_we = 1'b1;
        clr_nxt = clr_r + SW'(1);
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_if.valid) begin
          req_nxt = in_if.data.req_type;
          off_nxt = in_if.data.payload_offset;
          res_status_nxt = ffa_pkg::ST_OK;
          res_off_nxt = '0;
          res_bytes_nxt = '0;
          cur_nxt = first_r;
          step_nxt = '0;
          has_prev_nxt = 1'b0;
          found_nxt = 1'b0;
          pos_nxt = {1'b0, hsize};
          deg_nxt = 4'(ffa_pkg::MIN_DEGREE);
          need_nxt = {1'b0, in_if.data.alloc_bytes} + {1'b0, ffa_pkg::NODE_HDR_BYTES};
          case (in_if.data.req_type)
            ffa_pkg::REQ_ALLOC: begin
              if (in_if.data.alloc_bytes == '0 ||
                  in_if.data.alloc_bytes > ffa_pkg::REGION_LIMIT) begin
                res_status_nxt = ffa_pkg::ST_BAD_SIZE;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_DEG;
              end
            end
            ffa_pkg::REQ_FREE, ffa_pkg::REQ_QUERY: begin
              if (count_r == '0) begin
                res_status_nxt = ffa_pkg::ST_EMPTY;
                state_nxt = S_OUT;
              end else if (in_if.data.req_type == ffa_pkg::REQ_QUERY &&
                           {1'b0, in_if.data.payload_offset} == ffa_pkg::NODE_HDR_BYTES) begin
                res_bytes_nxt = hsize;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_WALK;
              end
            end
            default: begin
              res_status_nxt = ffa_pkg::ST_BAD_SIZE;
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      // Round the need up one degree per cycle; report a bad size past MAX_DEGREE or a full table.
      S_DEG: begin
        if (deg_r > 4'(ffa_pkg::MAX_DEGREE)) begin
          res_status_nxt = ffa_pkg::ST_BAD_SIZE;
          state_nxt = S_OUT;
        end else if ((16'd1 << deg_r) < need_r) begin
          deg_nxt = deg_r + 4'd1;
        end else if (count_r >= MAX_C) begin
          res_status_nxt = ffa_pkg::ST_FULL;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_WALK;
        end
      end
      // One linked block per cycle.
      S_WALK: begin
        if (req_r == ffa_pkg::REQ_ALLOC) begin
          if (step_r == count_r) begin
            state_nxt = S_PLACE;
          end else if ({1'b0, 2'b0, q_start} >= pos_plus) begin
            found_nxt = 1'b1;
            state_nxt = S_PLACE;
          end else begin
            if (q_end > pos_r) pos_nxt = q_end;
            prev_nxt = cur_r;  prev_start_nxt = q_start;  prev_deg_nxt = q_deg;
            has_prev_nxt = 1'b1;
            cur_nxt = q_next;
            step_nxt = step_r + CW'(1);
          end
        end else begin
          if (step_r == count_r) begin
            res_status_nxt = ffa_pkg::ST_NOT_FOUND;
            state_nxt = S_OUT;
          end else if (req_r == ffa_pkg::REQ_FREE && step_r == '0 &&
                       (off_r < q_start || {1'b0, off_r} >= reg_end)) begin
            res_status_nxt = ffa_pkg::ST_OUTSIDE;
            state_nxt = S_OUT;
          end else if (q_payload == {1'b0, off_r}) begin
            if (req_r == ffa_pkg::REQ_FREE) begin
              cur_next_nxt = q_next;
              cur_deg_nxt = q_deg;
              state_nxt = S_UNLINK;
            end else begin
              res_bytes_nxt = q_size;
              state_nxt = S_OUT;
            end
          end else begin
            prev_nxt = cur_r;  prev_start_nxt = q_start;  prev_deg_nxt = q_deg;
            has_prev_nxt = 1'b1;
            cur_nxt = q_next;
            step_nxt = step_r + CW'(1);
          end
        end
      end
      // Write the new block into the slot from the top of the stack, or report no space.
      S_PLACE: begin
        if (!found_r && pos_plus > {2'b0, reg_end}) begin
          res_status_nxt = ffa_pkg::ST_NO_SPACE;
          state_nxt = S_OUT;
        end else begin
          ent_we = 1'b1;
          ent_waddr = stk_q;
          ent_wdata[EW-1:SW+4] = pos_r[13:0];
          ent_wdata[SW+3:SW] = deg_r;
          if (has_prev_r) begin
            ent_wdata[SW-1:0] = found_r ? cur_r : '0;
            state_nxt = S_LINK;
          end else begin
            ent_wdata[SW-1:0] = (count_r != '0) ? first_r : '0;
            first_nxt = stk_q;
            state_nxt = S_OUT;
          end
          slot_nxt = stk_q;
          count_nxt = count_r + CW'(1);
          used_nxt = used_r + blk_size;
          res_off_nxt = pos_r[13:0] + 14'(ffa_pkg::NODE_HDR_BYTES);
          res_bytes_nxt = blk_size;
        end
      end
      // Point the previous block at the new one.
      S_LINK: begin
        ent_we = 1'b1;
        ent_waddr = prev_r;
        ent_wdata = {prev_start_r, prev_deg_r, slot_r};
        state_nxt = S_OUT;
      end
      // Unlink the freed block and push its slot.
      S_UNLINK: begin
        if (has_prev_r) begin
          ent_we = 1'b1;
          ent_waddr = prev_r;
          ent_wdata = {prev_start_r, prev_deg_r, cur_next_r};
        end else begin
          first_nxt = cur_next_r;
        end
        if (count_r == CW'(1)) begin
          first_nxt = '0;
        end
        count_nxt = count_r - CW'(1);
        stk_we = 1'b1;
        stk_waddr = SW'(MAX_C - count_r);
        stk_wdata = cur_r;
        used_nxt = used_r - 15'(16'd1 << cur_deg_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_nxt.status = res_status_r;
          out_nxt.result_offset = res_off_r;
          out_nxt.block_bytes = res_bytes_r;
          out_nxt.usage_bytes = used_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state with reset; payload registers without.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      first_r <= '0;
      count_r <= '0;
      used_r <= ffa_pkg::hdr_size(4'd5);
      region_r <= ffa_pkg::REGION_LIMIT;
      hlog_r <= 4'd5;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      first_r <= first_nxt;
      count_r <= count_nxt;
      used_r <= used_nxt;
      region_r <= region_nxt;
      hlog_r <= hlog_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r <= req_nxt;  off_r <= off_nxt;  deg_r <= deg_nxt;
    need_r <= need_nxt;  pos_r <= pos_nxt;  cur_r <= cur_nxt;  prev_r <= prev_nxt;
    prev_start_r <= prev_start_nxt;  prev_deg_r <= prev_deg_nxt;
    has_prev_r <= has_prev_nxt;  found_r <= found_nxt;  step_r <= step_nxt;
    slot_r <= slot_nxt;  cur_next_r <= cur_next_nxt;  cur_deg_r <= cur_deg_nxt;
    res_status_r <= res_status_nxt;  res_off_r <= res_off_nxt;
    res_bytes_r <= res_bytes_nxt;  out_r <= out_nxt;
  end
endmodule
`default_nettype wire
